// File: src/recursive_mutex_priority_inherit_unit_defines.svh
// assertion macros for the recursive mutex unit
// used by modules that sample clk and arst_n
`ifndef RECURSIVE_MUTEX_PRIORITY_INHERIT_UNIT_DEFINES_SVH
`define RECURSIVE_MUTEX_PRIORITY_INHERIT_UNIT_DEFINES_SVH

// same-cycle implication
`define RMPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RMPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rmpi_pkg.sv
// shared types and constants for the recursive mutex unit
// no dependencies
package rmpi_pkg;

	localparam int WAITER_DEPTH = 8;
	localparam int TASK_W       = 5;
	localparam int PRI_W        = 8;
	localparam int COUNT_W      = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [1:0] MODE_LOCK    = 2'd0;
	localparam logic [1:0] MODE_UNLOCK  = 2'd1;
	localparam logic [1:0] MODE_TIMEOUT = 2'd2;
	localparam logic [1:0] MODE_IGNORE  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BLOCK     = 3'd1;
	localparam logic [2:0] ST_TIMEOUT   = 3'd2;
	localparam logic [2:0] ST_NOT_OWNER = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	localparam logic [1:0] CELL_HOLD    = 2'd0;
	localparam logic [1:0] CELL_INSERT  = 2'd1;
	localparam logic [1:0] CELL_REMOVE  = 2'd2;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [PRI_W-1:0]  pri;
		logic [PRI_W-1:0]  base;
	} entry_t;

	typedef struct packed {
		logic [1:0]        op;
		logic              match_en;
		logic [TASK_W-1:0] id;
		entry_t            entry;
	} cell_cmd_t;

endpackage

// File: src/recursive_mutex_priority_inherit_unit.sv
// recursive mutex with one-level priority inheritance, waiters in a row of queue cells
// depends on rmpi_pkg, rmpi_cell and the assertion macro header
// each accepted beat is held in the input register until the output register is free, then its
// result is registered there; a new beat is accepted only after the previous one has left the
// input register, once the queue cells have been updated
// the output register lets the next beat enter while a result still waits
// reset clears ownership, the hold count and all queue valid bits
`include "recursive_mutex_priority_inherit_unit_defines.svh"
module recursive_mutex_priority_inherit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // task_id, task_priority, task_base_priority, no_wait
	input  logic [1:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // owner_valid, owner_id, owner_priority, boosted,
	                                   // woken_valid, woken_id, restored_priority
	output logic [2:0]  m_axis_tuser   // status
);
	import rmpi_pkg::*;

	// input stage
	logic              busy_q;
	logic [1:0]        mode_q;
	logic [TASK_W-1:0] id_q;
	logic [PRI_W-1:0]  pri_q;
	logic [PRI_W-1:0]  base_q;
	logic              nowait_q;

	// mutex state
	logic               held_q;
	logic [TASK_W-1:0]  holder_q;
	logic [PRI_W-1:0]   holder_pri_q;
	logic [PRI_W-1:0]   holder_base_q;
	logic [COUNT_W-1:0] count_q;

	// result register
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic               owner_valid_q;
	logic [TASK_W-1:0]  owner_id_q;
	logic [PRI_W-1:0]   owner_pri_q;
	logic               boosted_q;
	logic               woken_valid_q;
	logic [TASK_W-1:0]  woken_id_q;
	logic [PRI_W-1:0]   restored_q;

	logic fire;

	// queue chain
	cell_cmd_t cmd;
	logic      pop;
	logic      ge_c    [0:WAITER_DEPTH];
	logic      hit_c   [0:WAITER_DEPTH];
	logic      valid_c [0:WAITER_DEPTH+1];
	entry_t    entry_c [0:WAITER_DEPTH+1];
	logic      q_full;
	logic      q_nonempty;

	// next values
	logic               held_d;
	logic [TASK_W-1:0]  holder_d;
	logic [PRI_W-1:0]   holder_pri_d;
	logic [PRI_W-1:0]   holder_base_d;
	logic [COUNT_W-1:0] count_d;
	logic [2:0]         status_d;
	logic               boosted_d;
	logic               woken_valid_d;
	logic [TASK_W-1:0]  woken_id_d;
	logic [PRI_W-1:0]   restored_d;
	logic [1:0]         op_d;
	logic               match_d;

	assign s_axis_tready = !busy_q;
	assign fire          = busy_q && (!out_valid_q || m_axis_tready);

	assign ge_c[0]               = 1'b1;
	assign hit_c[0]              = pop;
	assign valid_c[0]            = 1'b1;
	assign entry_c[0]            = cmd.entry;
	assign valid_c[WAITER_DEPTH+1] = 1'b0;
	assign entry_c[WAITER_DEPTH+1] = '0;
	assign q_full                = valid_c[WAITER_DEPTH];
	assign q_nonempty            = valid_c[1];

	for (genvar i = 0; i < WAITER_DEPTH; i++) begin : g_cell
		rmpi_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_ge    (ge_c[i]),
			.left_hit   (hit_c[i]),
			.left_valid (valid_c[i]),
			.left_entry (entry_c[i]),
			.right_valid(valid_c[i+2]),
			.right_entry(entry_c[i+2]),
			.ge         (ge_c[i+1]),
			.hit        (hit_c[i+1]),
			.valid      (valid_c[i+1]),
			.entry      (entry_c[i+1])
		);
	end

	always_comb begin
		held_d        = held_q;
		holder_d      = holder_q;
		holder_pri_d  = holder_pri_q;
		holder_base_d = holder_base_q;
		count_d       = count_q;
		status_d      = ST_OK;
		boosted_d     = 1'b0;
		woken_valid_d = 1'b0;
		woken_id_d    = '0;
		restored_d    = '0;
		op_d          = CELL_HOLD;
		match_d       = 1'b0;
		pop           = 1'b0;
		unique case (mode_q)
			MODE_LOCK: begin
				if (!held_q) begin
					held_d        = 1'b1;
					holder_d      = id_q;
					holder_pri_d  = pri_q;
					holder_base_d = base_q;
					count_d       = COUNT_W'(1);
				end else if (holder_q == id_q) begin
					if (count_q == COUNT_MAX) begin
						status_d = ST_OVERFLOW;
					end else begin
						count_d = count_q + COUNT_W'(1);
					end
				end else if (nowait_q) begin
					status_d = ST_TIMEOUT;
				end else if (q_full) begin
					status_d = ST_FULL;
				end else begin
					if (pri_q > holder_pri_q) begin
						holder_pri_d = pri_q;
						boosted_d    = 1'b1;
					end
					op_d     = CELL_INSERT;
					status_d = ST_BLOCK;
				end
			end
			MODE_UNLOCK: begin
				if (!held_q || holder_q != id_q) begin
					status_d = ST_NOT_OWNER;
				end else if (count_q > COUNT_W'(1)) begin
					count_d = count_q - COUNT_W'(1);
				end else begin
					restored_d = holder_base_q;
					if (q_nonempty) begin
						holder_d      = entry_c[1].task_id;
						holder_pri_d  = entry_c[1].pri;
						holder_base_d = entry_c[1].base;
						count_d       = COUNT_W'(1);
						woken_valid_d = 1'b1;
						woken_id_d    = entry_c[1].task_id;
						op_d          = CELL_REMOVE;
						pop           = 1'b1;
					end else begin
						held_d        = 1'b0;
						holder_d      = '0;
						holder_pri_d  = '0;
						holder_base_d = '0;
						count_d       = '0;
					end
				end
			end
			MODE_TIMEOUT: begin
				if (!(held_q && holder_q == id_q)) begin
					status_d = ST_TIMEOUT;
					op_d     = CELL_REMOVE;
					match_d  = 1'b1;
				end
			end
			MODE_IGNORE: begin
			end
		endcase
		cmd.op            = fire ? op_d : CELL_HOLD;
		cmd.match_en      = match_d;
		cmd.id            = id_q;
		cmd.entry.task_id = id_q;
		cmd.entry.pri     = pri_q;
		cmd.entry.base    = base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			held_q        <= 1'b0;
			holder_q      <= '0;
			holder_pri_q  <= '0;
			holder_base_q <= '0;
			count_q       <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q   <= 1'b1;
				held_q        <= held_d;
				holder_q      <= holder_d;
				holder_pri_q  <= holder_pri_d;
				holder_base_q <= holder_base_d;
				count_q       <= count_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q   <= s_axis_tuser;
			id_q     <= s_axis_tdata[4:0];
			pri_q    <= s_axis_tdata[12:5];
			base_q   <= s_axis_tdata[20:13];
			nowait_q <= s_axis_tdata[21];
		end
		if (fire) begin
			status_q      <= status_d;
			owner_valid_q <= held_d;
			owner_id_q    <= held_d ? holder_d : '0;
			owner_pri_q   <= held_d ? holder_pri_d : '0;
			boosted_q     <= boosted_d;
			woken_valid_q <= woken_valid_d;
			woken_id_q    <= woken_id_d;
			restored_q    <= restored_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {3'b000, restored_q, woken_id_q, woken_valid_q, boosted_q,
		owner_pri_q, owner_id_q, owner_valid_q};

	`RMPI_ASSERT_NOW(a_waiters_need_owner, valid_c[1], held_q, "waiters queued on a free mutex")
	`RMPI_ASSERT_NOW(a_count_when_held, held_q, count_q != '0, "mutex held with zero count")
	`RMPI_ASSERT_NEXT(a_accept_sets_busy, s_axis_tvalid && s_axis_tready, busy_q, "accepted beat lost")
	`RMPI_ASSERT_NOW(a_woken_is_owner, m_axis_tvalid && m_axis_tdata[15], m_axis_tdata[0] && (m_axis_tdata[20:16] == m_axis_tdata[5:1]), "woken task is not the owner")

endmodule

// File: src/rmpi_cell.sv
// one slot of the sorted waiter queue
// depends on rmpi_pkg
module rmpi_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rmpi_pkg::cell_cmd_t cmd,
	input  logic               left_ge,
	input  logic               left_hit,
	input  logic               left_valid,
	input  rmpi_pkg::entry_t   left_entry,
	input  logic               right_valid,
	input  rmpi_pkg::entry_t   right_entry,
	output logic               ge,
	output logic               hit,
	output logic               valid,
	output rmpi_pkg::entry_t   entry
);
	import rmpi_pkg::*;

	logic   valid_q;
	entry_t entry_q;
	logic   match;

	assign ge    = valid_q && !(cmd.entry.pri > entry_q.pri);
	assign match = cmd.match_en && valid_q && (entry_q.task_id == cmd.id);
	assign hit   = left_hit || match;
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_INSERT: begin
					if (!ge) begin
						valid_q <= left_ge ? 1'b1 : left_valid;
					end
				end
				CELL_REMOVE: begin
					if (hit) begin
						valid_q <= right_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (!ge) begin
					entry_q <= left_ge ? cmd.entry : left_entry;
				end
			end
			CELL_REMOVE: begin
				if (hit) begin
					entry_q <= right_entry;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: tb/sv/recursive_mutex_priority_inherit_unit_tb.sv
// self-checking testbench for the recursive mutex unit with priority inheritance
// drives lock, unlock, timeout and ignore beats and compares every result beat with a local predictor
// depends on rmpi_pkg and recursive_mutex_priority_inherit_unit
module recursive_mutex_priority_inherit_unit_tb;
	import rmpi_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_BEATS = 1350;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TASK_W-1:0] task_id;
		logic [PRI_W-1:0]  pri;
		logic [PRI_W-1:0]  base;
		logic              no_wait;
	} request_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              owner_valid;
		logic [TASK_W-1:0] owner_id;
		logic [PRI_W-1:0]  owner_priority;
		logic              boosted;
		logic              woken_valid;
		logic [TASK_W-1:0] woken_id;
		logic [PRI_W-1:0]  restored;
	} result_t;

	typedef struct packed {
		logic                          held;
		logic [TASK_W-1:0]             holder;
		logic [PRI_W-1:0]              pri;
		logic [PRI_W-1:0]              base;
		logic [COUNT_W-1:0]            count;
		logic [3:0]                    depth;
		entry_t [WAITER_DEPTH-1:0]     waiters;
	} mutex_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // task_id, task_priority, task_base_priority, no_wait
	logic [1:0]  s_axis_tuser = '0;  // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // owner_valid, owner_id, owner_priority, boosted,
	                                 // woken_valid, woken_id, restored_priority
	logic [2:0]  m_axis_tuser;       // status

	request_t pending_requests[$];
	result_t  expected_results[$];
	mutex_t   issued_state;
	mutex_t   owner_state;
	int       total_beats;
	int       accepted_beats;
	int       results_seen;
	int       mismatches;
	int       cycles;

	recursive_mutex_priority_inherit_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void drop_waiter(inout mutex_t st, input int pos);
		for (int i = pos; i + 1 < st.depth; i++)
			st.waiters[i] = st.waiters[i + 1];
		st.depth = st.depth - 4'd1;
	endfunction

	function automatic result_t mutex_step(inout mutex_t st, input request_t rq);
		result_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		case (rq.mode)
			MODE_LOCK: begin
				if (!st.held) begin
					st.held = 1'b1;
					st.holder = rq.task_id;
					st.pri = rq.pri;
					st.base = rq.base;
					st.count = COUNT_W'(1);
				end else if (st.holder == rq.task_id) begin
					if (st.count == COUNT_MAX)
						r.status = ST_OVERFLOW;
					else
						st.count = st.count + COUNT_W'(1);
				end else if (rq.no_wait) begin
					r.status = ST_TIMEOUT;
				end else if (st.depth >= WAITER_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (rq.pri > st.pri) begin
						st.pri = rq.pri;
						r.boosted = 1'b1;
					end
					// highest priority first, arrival order among equals
					pos = 0;
					while (pos < st.depth && rq.pri <= st.waiters[pos].pri)
						pos++;
					for (int i = int'(st.depth); i > pos; i--)
						st.waiters[i] = st.waiters[i - 1];
					st.waiters[pos].task_id = rq.task_id;
					st.waiters[pos].pri = rq.pri;
					st.waiters[pos].base = rq.base;
					st.depth = st.depth + 4'd1;
					r.status = ST_BLOCK;
				end
			end
			MODE_UNLOCK: begin
				if (!st.held || st.holder != rq.task_id) begin
					r.status = ST_NOT_OWNER;
				end else if (st.count > COUNT_W'(1)) begin
					st.count = st.count - COUNT_W'(1);
				end else begin
					r.restored = st.base;
					if (st.depth > 0) begin
						st.holder = st.waiters[0].task_id;
						st.pri = st.waiters[0].pri;
						st.base = st.waiters[0].base;
						st.count = COUNT_W'(1);
						r.woken_valid = 1'b1;
						r.woken_id = st.waiters[0].task_id;
						drop_waiter(st, 0);
					end else begin
						st.held = 1'b0;
						st.holder = '0;
						st.pri = '0;
						st.base = '0;
						st.count = '0;
					end
				end
			end
			MODE_TIMEOUT: begin
				if (!(st.held && st.holder == rq.task_id)) begin
					r.status = ST_TIMEOUT;
					pos = -1;
					for (int i = 0; i < st.depth; i++)
						if (pos < 0 && st.waiters[i].task_id == rq.task_id)
							pos = i;
					if (pos >= 0)
						drop_waiter(st, pos);
				end
			end
			default: ;
		endcase
		r.owner_valid = st.held;
		r.owner_id = st.held ? st.holder : '0;
		r.owner_priority = st.held ? st.pri : '0;
		return r;
	endfunction

	task automatic add_request(input logic [1:0] mode, input int id, input int pri,
			input int base, input bit nw);
		request_t rq;
		rq.mode = mode;
		rq.task_id = TASK_W'(id);
		rq.pri = PRI_W'(pri);
		rq.base = PRI_W'(base);
		rq.no_wait = nw;
		pending_requests.push_back(rq);
		void'(mutex_step(issued_state, rq));
	endtask

	task automatic deep_recursion();
		while (issued_state.held)
			add_request(MODE_UNLOCK, int'(issued_state.holder), 0, 0, 0);
		add_request(MODE_LOCK, 12, 77, 40, 0);
		repeat (256)
			add_request(MODE_LOCK, 12, 77, 40, 1'($urandom_range(1)));
		add_request(MODE_LOCK, 13, 200, 9, 0);
		add_request(MODE_TIMEOUT, 12, 0, 0, 0);
		repeat (255)
			add_request(MODE_UNLOCK, 12, 0, 0, 0);
	endtask

	task automatic random_request();
		int sel;
		int id;
		int pri;
		int r;
		logic [1:0] mode;
		sel = $urandom_range(99);
		id = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(31);
		pri = ($urandom_range(3) == 0) ? $urandom_range(3) * 85 : $urandom_range(255);
		r = $urandom_range(9);
		if (sel < 45) begin
			mode = MODE_LOCK;
			if (issued_state.held && r < 3)
				id = int'(issued_state.holder);
		end else if (sel < 75) begin
			mode = MODE_UNLOCK;
			if (issued_state.held && r < 8)
				id = int'(issued_state.holder);
		end else if (sel < 95) begin
			mode = MODE_TIMEOUT;
			if (issued_state.depth > 0 && r < 6)
				id = int'(issued_state.waiters[$urandom_range(issued_state.depth - 1)].task_id);
			else if (issued_state.held && r < 8)
				id = int'(issued_state.holder);
		end else begin
			mode = MODE_IGNORE;
		end
		add_request(mode, id, pri, $urandom_range(255), $urandom_range(9) == 0);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("mismatch at result beat %0d: %s got %0d want %0d",
				results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input result_t got, input result_t want);
		if (got.status != want.status)
			report_mismatch("status", got.status, want.status);
		if (got.owner_valid != want.owner_valid)
			report_mismatch("owner_valid", got.owner_valid, want.owner_valid);
		if (got.owner_id != want.owner_id)
			report_mismatch("owner_id", got.owner_id, want.owner_id);
		if (got.owner_priority != want.owner_priority)
			report_mismatch("owner_priority", got.owner_priority, want.owner_priority);
		if (got.boosted != want.boosted)
			report_mismatch("boosted", got.boosted, want.boosted);
		if (got.woken_valid != want.woken_valid)
			report_mismatch("woken_valid", got.woken_valid, want.woken_valid);
		if (got.woken_id != want.woken_id)
			report_mismatch("woken_id", got.woken_id, want.woken_id);
		if (got.restored != want.restored)
			report_mismatch("restored_priority", got.restored, want.restored);
	endtask

	// phase 0: sender 15, receiver 45; phase 1 swapped; phase 2 no idling
	function automatic int idle_pct(input int done, input bit receiver);
		if (done < total_beats / 3)
			return receiver ? 45 : 15;
		else if (done < 2 * total_beats / 3)
			return receiver ? 15 : 45;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(mutex_step(owner_state,
					{s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[12:5],
					 s_axis_tdata[20:13], s_axis_tdata[21]}));
				accepted_beats++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() > 0 &&
						$urandom_range(99) >= idle_pct(accepted_beats, 1'b0)) begin
					request_t rq;
					rq = pending_requests.pop_front();
					s_axis_tdata <= {2'b00, rq.no_wait, rq.base, rq.pri, rq.task_id};
					s_axis_tuser <= rq.mode;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_t got;
				got.status = m_axis_tuser;
				got.owner_valid = m_axis_tdata[0];
				got.owner_id = m_axis_tdata[5:1];
				got.owner_priority = m_axis_tdata[13:6];
				got.boosted = m_axis_tdata[14];
				got.woken_valid = m_axis_tdata[15];
				got.woken_id = m_axis_tdata[20:16];
				got.restored = m_axis_tdata[28:21];
				if (expected_results.size() == 0)
					report_mismatch("result beat with nothing expected, status",
						got.status, 0);
				else
					check_result(got, expected_results.pop_front());
				results_seen++;
			end
			m_axis_tready <= $urandom_range(99) >= idle_pct(results_seen, 1'b1);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("recursive_mutex_priority_inherit_unit regression: fail");
			$finish;
		end
	end

	initial begin
		issued_state = '0;
		owner_state = '0;
		accepted_beats = 0;
		results_seen = 0;
		mismatches = 0;
		cycles = 0;

		// directed: error paths, recursion, boosting, ordering, full queue, handoff
		add_request(MODE_UNLOCK, 31, 0, 0, 0);
		add_request(MODE_TIMEOUT, 5, 0, 0, 0);
		add_request(MODE_LOCK, 0, 0, 0, 0);
		add_request(MODE_LOCK, 0, 0, 0, 0);
		add_request(MODE_UNLOCK, 3, 0, 0, 0);
		add_request(MODE_LOCK, 31, 255, 255, 1);
		add_request(MODE_LOCK, 1, 10, 10, 0);
		add_request(MODE_LOCK, 2, 10, 3, 0);
		add_request(MODE_LOCK, 3, 200, 50, 0);
		add_request(MODE_LOCK, 1, 5, 5, 0);
		add_request(MODE_LOCK, 4, 0, 0, 0);
		add_request(MODE_LOCK, 5, 255, 255, 0);
		add_request(MODE_LOCK, 6, 128, 1, 0);
		add_request(MODE_LOCK, 7, 10, 2, 0);
		add_request(MODE_LOCK, 30, 99, 99, 0);
		add_request(MODE_TIMEOUT, 2, 0, 0, 0);
		add_request(MODE_TIMEOUT, 0, 0, 0, 0);
		add_request(MODE_TIMEOUT, 20, 0, 0, 0);
		add_request(MODE_IGNORE, 9, 255, 255, 1);
		add_request(MODE_UNLOCK, 0, 0, 0, 0);
		add_request(MODE_UNLOCK, 0, 0, 0, 0);
		add_request(MODE_UNLOCK, 5, 0, 0, 0);
		add_request(MODE_TIMEOUT, 5, 0, 0, 0);

		while (pending_requests.size() < RANDOM_BEATS + 23) begin
			random_request();
			if (pending_requests.size() == 600)
				deep_recursion();
		end
		total_beats = pending_requests.size();

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (mismatches == 0)
			$display("recursive_mutex_priority_inherit_unit regression: pass");
		else
			$display("recursive_mutex_priority_inherit_unit regression: fail");
		$finish;
	end

endmodule
